### rtl/rsdf_pkg.sv
// ----------------------------------------------------------------------------
// rsdf_pkg
// Shared constants and types for the RootSIFT descriptor finishing block.
// ----------------------------------------------------------------------------
package rsdf_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CELLS           = 16;
    localparam int BINS            = 8;
    localparam int CELL_W          = 4;
    localparam int BIN_IDX_W       = 3;
    localparam int BYTE_W          = 8;
    localparam int NUM_BANKS       = 2;
    localparam int STORE_DEPTH     = NUM_BANKS * CELLS;
    localparam int STORE_ADDR_W    = CELL_W + 1;
    localparam int FRAC_SHIFT      = 20;
    localparam int OUT_DATA_W      = BINS * BYTE_W;

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

    // output byte m takes input bin (8-m) mod 8
    localparam logic [BIN_IDX_W-1:0] BIN_SRC [BINS] = '{
        3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1
    };

    typedef struct packed {
        logic full;
        logic empty;
        logic wr_bank;
        logic rd_bank;
    } t_qstat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD,
        B_LOAD,
        B_CALC,
        B_OUT
    } t_bstate;

endpackage

### rtl/rootsift_descriptor_finish_top.sv
// The back end starts on a descriptor once its 16th input cell is taken; each
// result cell then takes a RAM read, a load, 8 search steps of the root unit
// and an output load.
// Throughput: one input cell per cycle into a free bank; two descriptors fit in
// the store.
// Reset: synchronous, active low; clears counters, the running L1 sum, FSM state, queue and output valid only.
// ----------------------------------------------------------------------------
// rootsift_descriptor_finish_top
// RootSIFT descriptor finishing: L1 normalize, square root and byte quantize.
// ----------------------------------------------------------------------------
module rootsift_descriptor_finish_top import rsdf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // bin_0 .. bin_7, SAMPLE_BITS each, signed
    input  logic [BINS*SAMPLE_BITS-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // byte_0 .. byte_7, 8 bits each
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // cell_index
    output logic [CELL_W-1:0]           m_axis_tuser,
    output logic                        m_axis_tlast
);

    t_qstat                      qstat;
    logic                        st_we;
    logic [STORE_ADDR_W-1:0]     st_waddr;
    logic [BINS*SAMPLE_BITS-1:0] st_wdata;
    logic                        st_re;
    logic [STORE_ADDR_W-1:0]     st_raddr;
    logic [BINS*SAMPLE_BITS-1:0] st_rdata;
    logic                        q_push;
    logic                        q_pop;
    logic [SAMPLE_BITS+6:0]      q_l1_in;
    logic [SAMPLE_BITS+6:0]      q_l1_out;

    rsdf_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_qstat  (qstat),
        .o_we     (st_we),
        .o_waddr  (st_waddr),
        .o_wdata  (st_wdata),
        .o_push   (q_push),
        .o_l1     (q_l1_in)
    );

    rsdf_ram #(.WIDTH(BINS*SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    rsdf_jobq #(.SAMPLE_BITS(SAMPLE_BITS)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_l1    (q_l1_in),
        .i_pop   (q_pop),
        .o_l1    (q_l1_out),
        .o_qstat (qstat)
    );

    rsdf_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_l1     (q_l1_out),
        .i_qstat  (qstat),
        .o_pop    (q_pop),
        .o_re     (st_re),
        .o_raddr  (st_raddr),
        .i_rdata  (st_rdata),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

### rtl/rsdf_ram.sv
// ----------------------------------------------------------------------------
// rsdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rsdf_front.sv
// ----------------------------------------------------------------------------
// rsdf_front
// Input side: takes one cell per transfer, stores its bin magnitudes and
// accumulates the L1 sum; hands a finished descriptor to the job queue.
// ----------------------------------------------------------------------------
module rsdf_front import rsdf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [BINS*SAMPLE_BITS-1:0]   i_tdata,
    input  t_qstat                        i_qstat,
    output logic                          o_we,
    output logic [STORE_ADDR_W-1:0]       o_waddr,
    output logic [BINS*SAMPLE_BITS-1:0]   o_wdata,
    output logic                          o_push,
    output logic [SAMPLE_BITS+6:0]        o_l1
);

    localparam int L1_W = SAMPLE_BITS + 7;

    logic [CELL_W-1:0]        r_cnt;
    logic [CELL_W-1:0]        n_cnt;
    logic [L1_W-1:0]          r_sum;
    logic [L1_W-1:0]          n_sum;
    logic [L1_W-1:0]          sum_all;
    logic [SAMPLE_BITS-1:0]   mag [BINS];
    logic                     take;

    assign o_tready = !i_qstat.full;
    assign take     = i_tvalid && o_tready;

    always_comb begin
        sum_all = r_sum;
        for (int k = 0; k < BINS; k++) begin
            mag[k] = i_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
            if (mag[k][SAMPLE_BITS-1]) begin
                mag[k] = ~mag[k] + SAMPLE_BITS'(1);
            end
            o_wdata[k*SAMPLE_BITS +: SAMPLE_BITS] = mag[k];
            sum_all = sum_all + L1_W'(mag[k]);
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        o_push = 1'b0;
        if (take) begin
            n_cnt = r_cnt + CELL_W'(1);
            if (r_cnt == LAST_CELL) begin
                o_push = 1'b1;
                n_sum  = '0;
            end else begin
                n_sum  = sum_all;
            end
        end
    end

    assign o_we    = take;
    assign o_waddr = {i_qstat.wr_bank, r_cnt};
    assign o_l1    = sum_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
        end
    end

endmodule

### rtl/rsdf_jobq.sv
// ----------------------------------------------------------------------------
// rsdf_jobq
// Two-entry descriptor queue. Each entry owns one bank of the cell store
// and holds its L1 sum until the back end has loaded its last cell for output.
// ----------------------------------------------------------------------------
module rsdf_jobq import rsdf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [SAMPLE_BITS+6:0] i_l1,
    input  logic                   i_pop,
    output logic [SAMPLE_BITS+6:0] o_l1,
    output t_qstat                 o_qstat
);

    logic [SAMPLE_BITS+6:0] r_l1 [NUM_BANKS];
    logic                   r_wptr;
    logic                   r_rptr;
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_l1[r_wptr] <= i_l1;
        end
    end

    assign o_l1            = r_l1[r_rptr];
    assign o_qstat.full    = (r_cnt == 2'(NUM_BANKS));
    assign o_qstat.empty   = (r_cnt == 2'd0);
    assign o_qstat.wr_bank = r_wptr;
    assign o_qstat.rd_bank = r_rptr;

endmodule

### rtl/rsdf_back.sv
// ----------------------------------------------------------------------------
// rsdf_back
// Output side: reads one stored cell at a time and runs eight parallel
// bit-by-bit searches for the rounded root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rsdf_back import rsdf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [SAMPLE_BITS+6:0]      i_l1,
    input  t_qstat                      i_qstat,
    output logic                        o_pop,
    output logic                        o_re,
    output logic [STORE_ADDR_W-1:0]     o_raddr,
    input  logic [BINS*SAMPLE_BITS-1:0] i_rdata,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [OUT_DATA_W-1:0]       o_tdata,
    output logic [CELL_W-1:0]           o_tuser,
    output logic                        o_tlast
);

    localparam int L1_W  = SAMPLE_BITS + 7;
    localparam int T_W   = SAMPLE_BITS + FRAC_SHIFT;
    localparam int ACC_W = SAMPLE_BITS + 25;
    localparam int EL_W  = SAMPLE_BITS + 18;
    localparam int SUM_W = SAMPLE_BITS + 27;

    t_bstate                  r_state;
    t_bstate                  n_state;
    logic [CELL_W-1:0]        r_cell;
    logic [CELL_W-1:0]        n_cell;
    logic [BIN_IDX_W-1:0]     r_step;
    logic [BIN_IDX_W-1:0]     n_step;
    logic                     r_ovalid;
    logic                     n_ovalid;
    logic [OUT_DATA_W-1:0]    r_obytes;
    logic [CELL_W-1:0]        r_ocell;
    logic                     r_olast;
    logic                     out_load;

    // per-lane search state: e = 2r-1, e2 = e*e*L1, el = e*L1
    logic [SAMPLE_BITS-1:0]   r_mag [BINS];
    logic [BYTE_W-1:0]        r_res [BINS];
    logic [ACC_W-1:0]         r_e2  [BINS];
    logic signed [EL_W-1:0]   r_el  [BINS];

    logic [BIN_IDX_W-1:0]     bit_b;
    logic signed [SUM_W-1:0]  trial [BINS];
    logic                     ok    [BINS];
    logic [OUT_DATA_W-1:0]    n_obytes;
    logic                     l1_zero;

    assign bit_b   = BIN_IDX_W'(BINS - 1) - r_step;
    assign l1_zero = (i_l1 == '0);

    always_comb begin
        for (int i = 0; i < BINS; i++) begin
            trial[i] = $signed({{(SUM_W-ACC_W){1'b0}}, r_e2[i]})
                     + (SUM_W'(r_el[i]) <<< ({1'b0, bit_b} + 4'd2))
                     + ($signed({{(SUM_W-L1_W){1'b0}}, i_l1}) <<< ({1'b0, bit_b, 1'b0} + 5'd2));
            ok[i] = (trial[i][ACC_W-1:0] <=
                     {{(ACC_W-T_W){1'b0}}, r_mag[i], {FRAC_SHIFT{1'b0}}});
        end
    end

    always_comb begin
        for (int m = 0; m < BINS; m++) begin
            n_obytes[m*BYTE_W +: BYTE_W] = l1_zero ? '0 : r_res[BIN_SRC[m]];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cell   = r_cell;
        n_step   = r_step;
        n_ovalid = r_ovalid && !i_tready;
        o_pop    = 1'b0;
        o_re     = 1'b0;
        out_load = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = B_RD;
                end
            end
            B_RD: begin
                o_re    = 1'b1;
                n_state = B_LOAD;
            end
            B_LOAD: begin
                n_step  = '0;
                n_state = B_CALC;
            end
            B_CALC: begin
                n_step = r_step + BIN_IDX_W'(1);
                if (r_step == BIN_IDX_W'(BINS - 1)) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                // wait for the output register to drain
                if (!r_ovalid || i_tready) begin
                    out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_cell   = r_cell + CELL_W'(1);
                    if (r_cell == LAST_CELL) begin
                        o_pop   = 1'b1;
                        n_state = B_IDLE;
                    end else begin
                        n_state = B_RD;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_raddr = {i_qstat.rd_bank, r_cell};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cell   <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cell   <= n_cell;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BINS; i++) begin
            if (r_state == B_LOAD) begin
                r_mag[i] <= i_rdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                r_res[i] <= '0;
                r_e2[i]  <= ACC_W'(i_l1);
                r_el[i]  <= -$signed({{(EL_W-L1_W){1'b0}}, i_l1});
            end else if (r_state == B_CALC && ok[i]) begin
                r_res[i] <= r_res[i] | (BYTE_W'(1) << bit_b);
                r_e2[i]  <= trial[i][ACC_W-1:0];
                r_el[i]  <= r_el[i]
                          + ($signed({{(EL_W-L1_W){1'b0}}, i_l1}) <<< ({1'b0, bit_b} + 4'd1));
            end
        end
        if (out_load) begin
            r_obytes <= n_obytes;
            r_ocell  <= r_cell;
            r_olast  <= (r_cell == LAST_CELL);
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_obytes;
    assign o_tuser  = r_ocell;
    assign o_tlast  = r_olast;

endmodule

### rtl/rsdf_checker.sv
// ----------------------------------------------------------------------------
// rsdf_checker
// Port-level checks on the result stream of the descriptor finishing block.
// ----------------------------------------------------------------------------
module rsdf_checker import rsdf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [CELL_W-1:0]     m_axis_tuser,
    input logic                  m_axis_tlast
);

    logic [CELL_W-1:0] r_exp;

    // track the cell index the next result transfer must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_exp <= r_exp + CELL_W'(1);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_CELL)))
        else $error("tlast does not match final cell");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == r_exp))
        else $error("result cell out of order");

endmodule

bind rootsift_descriptor_finish_top rsdf_checker u_rsdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### test/rsdf_checker.sv
// ----------------------------------------------------------------------------
// rsdf_tb_checker
// Watches both stream channels of the descriptor finishing block. It rebuilds
// each descriptor from the input transfers, works out the sixteen quantized
// cells when the last one lands, and compares every output transfer with the
// oldest cell still owed.
// ----------------------------------------------------------------------------
module rsdf_tb_checker import rsdf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    // bin_0 .. bin_7, SAMPLE_BITS each, signed
    input  logic [BINS*SAMPLE_BITS-1:0] i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    // byte_0 .. byte_7, 8 bits each
    input  logic [OUT_DATA_W-1:0]       i_out_data,
    // cell_index
    input  logic [CELL_W-1:0]           i_out_cell,
    input  logic                        i_out_last,
    output int                          o_pending,
    output int                          o_errors
);

    localparam int MAX_BYTE = 255;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] bytes;
        logic [CELL_W-1:0]     idx;
        logic                  last;
    } t_cell_result;

    logic [BINS*SAMPLE_BITS-1:0] held_cells [CELLS];
    logic [SAMPLE_BITS+6:0]      l1_sum = '0;
    int                          cells_held = 0;
    t_cell_result                owed_cells [$];
    int                          mismatch_count = 0;

    // magnitude of a two's complement sample; the most negative one fits too
    function automatic logic [SAMPLE_BITS:0] bin_mag(input logic [SAMPLE_BITS-1:0] raw);
        logic [SAMPLE_BITS:0] wide;
        wide = {raw[SAMPLE_BITS-1], raw};
        return wide[SAMPLE_BITS] ? -wide : wide;
    endfunction

    // smallest n with (2n+1)^2 * l1 > 2^20 * mag, saturated
    function automatic logic [BYTE_W-1:0] root_byte(input longint unsigned mag,
                                                    input longint unsigned l1);
        longint unsigned bound;
        longint unsigned odd;
        if (l1 == 0) return '0;
        bound = mag << FRAC_SHIFT;
        for (int n = 0; n < MAX_BYTE; n++) begin
            odd = 2 * n + 1;
            if (odd * odd * l1 > bound) return BYTE_W'(n);
        end
        return BYTE_W'(MAX_BYTE);
    endfunction

    task automatic quantize_descriptor();
        t_cell_result           res;
        logic [SAMPLE_BITS-1:0] raw;
        int                     src;
        for (int c = 0; c < CELLS; c++) begin
            for (int m = 0; m < BINS; m++) begin
                src = (BINS - m) % BINS;
                raw = held_cells[c][src*SAMPLE_BITS +: SAMPLE_BITS];
                res.bytes[m*BYTE_W +: BYTE_W] = root_byte(bin_mag(raw), l1_sum);
            end
            res.idx  = CELL_W'(c);
            res.last = (c == CELLS - 1);
            owed_cells.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            l1_sum     = '0;
            cells_held = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                held_cells[cells_held] = i_in_data;
                for (int b = 0; b < BINS; b++)
                    l1_sum += bin_mag(i_in_data[b*SAMPLE_BITS +: SAMPLE_BITS]);
                cells_held++;
                if (cells_held == CELLS) begin
                    quantize_descriptor();
                    l1_sum     = '0;
                    cells_held = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_cells.size() == 0) begin
                    report_mismatch("result with nothing owed, cell", i_out_cell, -1);
                end else begin
                    want = owed_cells.pop_front();
                    for (int m = 0; m < BINS; m++) begin
                        if (i_out_data[m*BYTE_W +: BYTE_W] !== want.bytes[m*BYTE_W +: BYTE_W])
                            report_mismatch($sformatf("cell %0d byte_%0d", want.idx, m),
                                            i_out_data[m*BYTE_W +: BYTE_W],
                                            want.bytes[m*BYTE_W +: BYTE_W]);
                    end
                    if (i_out_cell !== want.idx)
                        report_mismatch("cell_index", i_out_cell, want.idx);
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("cell %0d last_cell", want.idx),
                                        i_out_last, want.last);
                end
            end
        end
        o_pending <= owed_cells.size();
        o_errors  <= mismatch_count;
    end

endmodule

### test/tb_rootsift_descriptor_finish_top.sv
// ----------------------------------------------------------------------------
// tb_rootsift_descriptor_finish_top
// Drives whole descriptors into the finishing block: a directed one with
// extreme, tiny and ordered bins, then random ones of several shapes, under
// three idling mixes on the two channels. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rootsift_descriptor_finish_top;
    import rsdf_pkg::*;

    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int RANDOM_DESCS  = 28;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum int {
        SHAPE_ZERO,
        SHAPE_ALL_MIN,
        SHAPE_FULL,
        SHAPE_SPARSE,
        SHAPE_SMALL,
        SHAPE_PEAK
    } t_shape;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    // bin_0 .. bin_7, SAMPLE_BITS each, signed
    logic [BINS*SAMPLE_BITS-1:0] s_axis_tdata = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // byte_0 .. byte_7, 8 bits each
    logic [OUT_DATA_W-1:0]       m_axis_tdata;
    // cell_index
    logic [CELL_W-1:0]           m_axis_tuser;
    logic                        m_axis_tlast;

    int pending_cells;
    int error_count;
    int send_idle_pct = 15;
    int recv_idle_pct = 55;
    int cycle_count = 0;

    rootsift_descriptor_finish_top #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsdf_tb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_cell  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_pending   (pending_cells),
        .o_errors    (error_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold the cell on the bus until the transfer happens
    task automatic send_cell(input logic [BINS*SAMPLE_BITS-1:0] cell_word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cell_word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cells != 0);
    endtask

    // extremes, tiny bins and signed ramps whose order shows the bin reversal
    task automatic send_directed_descriptor();
        logic [BINS*SAMPLE_BITS-1:0] cell_word;
        int                          sgn;
        for (int c = 0; c < CELLS; c++) begin
            cell_word = '0;
            for (int b = 0; b < BINS; b++) begin
                sgn = (b % 2) ? -1 : 1;
                if (c == 0 && b == 0)
                    cell_word[b*SAMPLE_BITS +: SAMPLE_BITS] = MOST_NEG;
                else if (c == 0 && b == 1)
                    cell_word[b*SAMPLE_BITS +: SAMPLE_BITS] = MOST_POS;
                else if (c == 1)
                    cell_word[b*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(sgn * (b / 2 + 1));
                else if (c == 2)
                    cell_word[b*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(sgn * 100 * (b + 1));
            end
            send_cell(cell_word);
        end
    endtask

    task automatic send_random_descriptor(input t_shape shape);
        logic [BINS*SAMPLE_BITS-1:0] cell_word;
        logic [SAMPLE_BITS-1:0]      bin_val;
        int                          peak_cell;
        int                          peak_bin;
        peak_cell = $urandom_range(CELLS - 1);
        peak_bin  = $urandom_range(BINS - 1);
        for (int c = 0; c < CELLS; c++) begin
            for (int b = 0; b < BINS; b++) begin
                case (shape)
                    SHAPE_ZERO:    bin_val = '0;
                    SHAPE_ALL_MIN: bin_val = MOST_NEG;
                    SHAPE_FULL:    bin_val = SAMPLE_BITS'($urandom);
                    SHAPE_SPARSE:  bin_val = ($urandom_range(7) == 0) ?
                                             SAMPLE_BITS'($urandom) : '0;
                    SHAPE_SMALL:   bin_val = SAMPLE_BITS'(int'($urandom_range(16)) - 8);
                    default: begin
                        // one huge bin drowns the rest and saturates
                        if (c == peak_cell && b == peak_bin)
                            bin_val = $urandom_range(1) ? MOST_POS : MOST_NEG;
                        else
                            bin_val = SAMPLE_BITS'(int'($urandom_range(64)) - 32);
                    end
                endcase
                cell_word[b*SAMPLE_BITS +: SAMPLE_BITS] = bin_val;
            end
            send_cell(cell_word);
        end
    endtask

    initial begin
        t_shape shape;
        int     pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_directed_descriptor();

        for (int d = 0; d < RANDOM_DESCS; d++) begin
            if (d == 10) begin
                send_idle_pct = 55;
                recv_idle_pct = 15;
            end else if (d == 20) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (d == 0) begin
                shape = SHAPE_ZERO;
            end else if (d == 1) begin
                shape = SHAPE_ALL_MIN;
            end else begin
                pick = $urandom_range(9);
                if (pick < 4)      shape = SHAPE_FULL;
                else if (pick < 6) shape = SHAPE_SPARSE;
                else if (pick < 8) shape = SHAPE_SMALL;
                else if (pick < 9) shape = SHAPE_PEAK;
                else               shape = SHAPE_ZERO;
            end
            // let the block empty completely now and then
            if (d == 4 || d == 14) drain_results();
            send_random_descriptor(shape);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
